// File: sv/phdc_pkg.sv
// Shared constants and codes for the probe hit decision classifier
`default_nettype none

package phdc_pkg;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int GENE_W   = 15;
    localparam int CLASS_W  = 8;
    localparam int CODE_W   = 8;
    localparam int OFF_W    = 8;
    localparam int ACTION_W = 2;

    // stream word widths, padded to whole bytes
    localparam int S_FIELDS_W = SAMPLE_W + GENE_W + CLASS_W + CODE_W + OFF_W + SAMPLE_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = ACTION_W + GENE_W + CLASS_W + CODE_W + OFF_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    // configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_ADDR_W-1:0] CFG_NO_NEGATIVE_CODE     = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PROBE_AMBIGUOUS_CODE = 1'b1;
    localparam logic [CFG_DATA_W-1:0] NO_NEGATIVE_CODE_RST     = 8'd0;
    localparam logic [CFG_DATA_W-1:0] PROBE_AMBIGUOUS_CODE_RST = 8'd1;

    // decision codes
    localparam logic [ACTION_W-1:0] ACTION_PASS = 2'd0;
    localparam logic [ACTION_W-1:0] ACTION_KEEP = 2'd1;
    localparam logic [ACTION_W-1:0] ACTION_DENY = 2'd2;

    // cache classes
    localparam logic [CLASS_W-1:0] CLASS_EXACT = 8'd0;
    localparam logic [CLASS_W-1:0] CLASS_KEEP  = 8'd1;
    localparam logic [CLASS_W-1:0] CLASS_DENY  = 8'd2;
    localparam logic [CLASS_W-1:0] CLASS_KEEP3 = 8'd3;

endpackage : phdc_pkg

`default_nettype wire

// File: sv/probe_hit_decision_classifier_unit.sv
// Top level: per-read hit classification with sticky flags and one decision per read
//
//  channel | ports                       | contents
//  --------+-----------------------------+--------------------------------------------
//  input   | s_tvalid/s_tready/s_tdata   | one lookup hit per word, s_tlast ends read
//  result  | m_tvalid/m_tready/m_tdata   | one decision word per read
//  config  | cfg_we/cfg_addr/cfg_wdata   | code registers, write only
//
// A hit is taken every cycle while the input register can advance; it passes through
// the input register, and the decision for its read is registered in the result register.
// aresetn is synchronous; it clears the flags and valids and resets the code registers.
// A stalled result only holds back the input register when the waiting hit ends a
// read; hits that do not end a read keep flowing past a full result register.
`default_nettype none

module probe_hit_decision_classifier_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // config port
    input  wire logic                              cfg_we,
    input  wire logic [phdc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [phdc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input hits
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // hit_sample, hit_gene, hit_class, hit_neg_code, hit_offset, read_sample
    input  wire logic [phdc_pkg::S_DATA_W-1:0]     s_tdata,
    // hit_valid
    input  wire logic                              s_tuser,
    input  wire logic                              s_tlast,
    // decisions
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // action, gene_index, class_out, negative_code, decision_offset
    output logic [phdc_pkg::M_DATA_W-1:0]          m_tdata
);
    import phdc_pkg::*;

    // config registers
    logic [CODE_W-1:0] no_neg_code_reg;
    logic [CODE_W-1:0] amb_code_reg;

    // input register
    logic                in_valid_reg;
    logic                in_hit_reg;
    logic                in_last_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;
    logic [GENE_W-1:0]   in_gene_reg;
    logic [CLASS_W-1:0]  in_class_reg;
    logic [CODE_W-1:0]   in_code_reg;
    logic [OFF_W-1:0]    in_off_reg;
    logic [SAMPLE_W-1:0] in_rsample_reg;

    // sticky per-read state
    logic                exact_reg,     exact_next;
    logic [GENE_W-1:0]   keep_gene_reg, keep_gene_next;
    logic [CLASS_W-1:0]  keep_class_reg, keep_class_next;
    logic [OFF_W-1:0]    keep_off_reg,  keep_off_next;
    logic                amb_reg,       amb_next;
    logic [CODE_W-1:0]   amb_c_reg,     amb_c_next;
    logic [OFF_W-1:0]    amb_off_reg,   amb_off_next;
    logic                mis_reg,       mis_next;
    logic [OFF_W-1:0]    mis_off_reg,   mis_off_next;
    logic                nex_reg,       nex_next;
    logic [GENE_W-1:0]   nex_gene_reg,  nex_gene_next;
    logic [SAMPLE_W-1:0] nex_key_reg,   nex_key_next;
    logic [CLASS_W-1:0]  nex_class_reg, nex_class_next;
    logic [OFF_W-1:0]    nex_off_reg,   nex_off_next;
    logic                conf_reg,      conf_next;
    logic [OFF_W-1:0]    conf_off_reg,  conf_off_next;

    // result register
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic [M_DATA_W-1:0] m_data_next;

    logic out_free;
    logic advance;
    logic matched;
    logic other;
    logic keep_class;

    // handshake
    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign matched    = (in_sample_reg != '0) && (in_sample_reg == in_rsample_reg);
    assign other      = (in_sample_reg != '0) && (in_sample_reg != in_rsample_reg);
    assign keep_class = (in_class_reg == CLASS_EXACT) || (in_class_reg == CLASS_KEEP)
                     || (in_class_reg == CLASS_KEEP3);

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            no_neg_code_reg <= NO_NEGATIVE_CODE_RST;
            amb_code_reg    <= PROBE_AMBIGUOUS_CODE_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_NO_NEGATIVE_CODE:     no_neg_code_reg <= cfg_wdata;
                CFG_PROBE_AMBIGUOUS_CODE: amb_code_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_hit_reg     <= s_tuser;
            in_last_reg    <= s_tlast;
            in_sample_reg  <= s_tdata[15:0];
            in_gene_reg    <= s_tdata[30:16];
            in_class_reg   <= s_tdata[38:31];
            in_code_reg    <= s_tdata[46:39];
            in_off_reg     <= s_tdata[54:47];
            in_rsample_reg <= s_tdata[70:55];
        end
    end

    // hit classification and state update
    always_comb begin
        exact_next      = exact_reg;
        keep_gene_next  = keep_gene_reg;
        keep_class_next = keep_class_reg;
        keep_off_next   = keep_off_reg;
        amb_next        = amb_reg;
        amb_c_next      = amb_c_reg;
        amb_off_next    = amb_off_reg;
        mis_next        = mis_reg;
        mis_off_next    = mis_off_reg;
        nex_next        = nex_reg;
        nex_gene_next   = nex_gene_reg;
        nex_key_next    = nex_key_reg;
        nex_class_next  = nex_class_reg;
        nex_off_next    = nex_off_reg;
        conf_next       = conf_reg;
        conf_off_next   = conf_off_reg;
        if (in_hit_reg && !exact_reg) begin
            priority if ((in_gene_reg == '0) || (in_class_reg == CLASS_DENY)) begin
                // ambiguous or deny record, latest wins
                amb_next     = 1'b1;
                amb_c_next   = (in_code_reg != no_neg_code_reg) ? in_code_reg : amb_code_reg;
                amb_off_next = in_off_reg;
            end else if ((in_class_reg == CLASS_EXACT) && matched) begin
                // exact keep, rest of read ignored
                exact_next      = 1'b1;
                keep_gene_next  = in_gene_reg;
                keep_class_next = in_class_reg;
                keep_off_next   = in_off_reg;
            end else if (keep_class && other) begin
                // record for another sample, first one kept
                if (!mis_reg) begin
                    mis_next     = 1'b1;
                    mis_off_next = in_off_reg;
                end
            end else if (keep_class) begin
                // non-exact keep, later disagreement is a conflict
                if (!nex_reg) begin
                    nex_next       = 1'b1;
                    nex_gene_next  = in_gene_reg;
                    nex_key_next   = matched ? in_rsample_reg : '0;
                    nex_class_next = in_class_reg;
                    nex_off_next   = in_off_reg;
                end else if ((nex_gene_reg != in_gene_reg)
                          || (nex_key_reg != (matched ? in_rsample_reg : '0))) begin
                    conf_next     = 1'b1;
                    conf_off_next = in_off_reg;
                end
            end else begin
                // unknown class ignored
            end
        end
    end

    // decision from the updated state
    always_comb begin
        priority if (exact_next) begin
            m_data_next = {{(M_DATA_W-M_FIELDS_W){1'b0}}, keep_off_next, {CODE_W{1'b0}},
                           keep_class_next, keep_gene_next, ACTION_KEEP};
        end else if (amb_next) begin
            m_data_next = {{(M_DATA_W-M_FIELDS_W){1'b0}}, amb_off_next, amb_c_next,
                           {CLASS_W{1'b0}}, {GENE_W{1'b0}}, ACTION_DENY};
        end else if (conf_next) begin
            m_data_next = {{(M_DATA_W-M_FIELDS_W){1'b0}}, conf_off_next, amb_code_reg,
                           {CLASS_W{1'b0}}, {GENE_W{1'b0}}, ACTION_DENY};
        end else if (nex_next) begin
            m_data_next = {{(M_DATA_W-M_FIELDS_W){1'b0}}, nex_off_next, {CODE_W{1'b0}},
                           nex_class_next, nex_gene_next, ACTION_KEEP};
        end else if (mis_next) begin
            m_data_next = {{(M_DATA_W-M_FIELDS_W){1'b0}}, mis_off_next, amb_code_reg,
                           {CLASS_W{1'b0}}, {GENE_W{1'b0}}, ACTION_DENY};
        end else begin
            m_data_next = {{(M_DATA_W-ACTION_W){1'b0}}, ACTION_PASS};
        end
    end

    // sticky flags, cleared after each decision
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exact_reg <= 1'b0;
            amb_reg   <= 1'b0;
            mis_reg   <= 1'b0;
            nex_reg   <= 1'b0;
            conf_reg  <= 1'b0;
        end else if (advance) begin
            if (in_last_reg) begin
                exact_reg <= 1'b0;
                amb_reg   <= 1'b0;
                mis_reg   <= 1'b0;
                nex_reg   <= 1'b0;
                conf_reg  <= 1'b0;
            end else begin
                exact_reg <= exact_next;
                amb_reg   <= amb_next;
                mis_reg   <= mis_next;
                nex_reg   <= nex_next;
                conf_reg  <= conf_next;
            end
        end
    end

    // captured fields
    always_ff @(posedge aclk) begin
        if (advance) begin
            keep_gene_reg  <= keep_gene_next;
            keep_class_reg <= keep_class_next;
            keep_off_reg   <= keep_off_next;
            amb_c_reg      <= amb_c_next;
            amb_off_reg    <= amb_off_next;
            mis_off_reg    <= mis_off_next;
            nex_gene_reg   <= nex_gene_next;
            nex_key_reg    <= nex_key_next;
            nex_class_reg  <= nex_class_next;
            nex_off_reg    <= nex_off_next;
            conf_off_reg   <= conf_off_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance && in_last_reg) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule : probe_hit_decision_classifier_unit

`default_nettype wire

// File: tb/sv/tb_top.sv
// Testbench for the probe hit decision classifier: queue-fed driver, checking monitor
`timescale 1ns / 100ps

module tb_top;
    import phdc_pkg::*;

    // one lookup hit as seen on the input stream
    typedef struct {
        logic                valid;
        logic [SAMPLE_W-1:0] sample;
        logic [GENE_W-1:0]   gene;
        logic [CLASS_W-1:0]  cls;
        logic [CODE_W-1:0]   code;
        logic [OFF_W-1:0]    off;
        logic [SAMPLE_W-1:0] rsample;
        logic                last;
    } hit_t;

    // one decision word
    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [GENE_W-1:0]   gene;
        logic [CLASS_W-1:0]  cls;
        logic [CODE_W-1:0]   code;
        logic [OFF_W-1:0]    off;
    } decision_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    probe_hit_decision_classifier_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 2 ns clock
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    hit_t      pending_hits[$];
    decision_t expected_decisions[$];
    int        errors = 0;
    int        decisions_seen = 0;
    bit        steady = 1'b0;

    // register copies
    logic [CODE_W-1:0] nonneg_code = NO_NEGATIVE_CODE_RST;
    logic [CODE_W-1:0] ambig_code  = PROBE_AMBIGUOUS_CODE_RST;

    // per-read sticky state of the predictor
    logic                exact_seen = 1'b0;
    logic [GENE_W-1:0]   exact_gene = '0;
    logic [CLASS_W-1:0]  exact_cls  = '0;
    logic [OFF_W-1:0]    exact_off  = '0;
    logic                deny_seen  = 1'b0;
    logic [CODE_W-1:0]   deny_code  = '0;
    logic [OFF_W-1:0]    deny_off   = '0;
    logic                stray_seen = 1'b0;
    logic [OFF_W-1:0]    stray_off  = '0;
    logic                loose_seen = 1'b0;
    logic [GENE_W-1:0]   loose_gene = '0;
    logic [SAMPLE_W-1:0] loose_key  = '0;
    logic [CLASS_W-1:0]  loose_cls  = '0;
    logic [OFF_W-1:0]    loose_off  = '0;
    logic                clash_seen = 1'b0;
    logic [OFF_W-1:0]    clash_off  = '0;

    // append one word to the pending input queue
    function automatic void queue_hit(hit_t h);
        pending_hits = {pending_hits, h};
    endfunction

    // classify one accepted hit; a read-ending hit yields the expected decision
    function automatic void classify_hit(hit_t h);
        logic                matched;
        logic                other;
        logic                keep_cls;
        logic [SAMPLE_W-1:0] key;
        decision_t           d;
        if (h.valid && !exact_seen) begin
            matched  = (h.sample != '0) && (h.sample == h.rsample);
            other    = (h.sample != '0) && (h.sample != h.rsample);
            keep_cls = (h.cls == CLASS_EXACT) || (h.cls == CLASS_KEEP) ||
                       (h.cls == CLASS_KEEP3);
            if (h.gene == '0 || h.cls == CLASS_DENY) begin
                deny_seen = 1'b1;
                deny_code = (h.code != nonneg_code) ? h.code : ambig_code;
                deny_off  = h.off;
            end else if (h.cls == CLASS_EXACT && matched) begin
                exact_seen = 1'b1;
                exact_gene = h.gene;
                exact_cls  = h.cls;
                exact_off  = h.off;
            end else if (keep_cls) begin
                if (other) begin
                    if (!stray_seen) begin
                        stray_seen = 1'b1;
                        stray_off  = h.off;
                    end
                end else begin
                    key = matched ? h.rsample : '0;
                    if (!loose_seen) begin
                        loose_seen = 1'b1;
                        loose_gene = h.gene;
                        loose_key  = key;
                        loose_cls  = h.cls;
                        loose_off  = h.off;
                    end else if (loose_gene != h.gene || loose_key != key) begin
                        clash_seen = 1'b1;
                        clash_off  = h.off;
                    end
                end
            end
        end
        if (h.last) begin
            d = '{action: ACTION_PASS, gene: '0, cls: '0, code: '0, off: '0};
            if (exact_seen) begin
                d.action = ACTION_KEEP;
                d.gene   = exact_gene;
                d.cls    = exact_cls;
                d.off    = exact_off;
            end else if (deny_seen) begin
                d.action = ACTION_DENY;
                d.code   = deny_code;
                d.off    = deny_off;
            end else if (clash_seen) begin
                d.action = ACTION_DENY;
                d.code   = ambig_code;
                d.off    = clash_off;
            end else if (loose_seen) begin
                d.action = ACTION_KEEP;
                d.gene   = loose_gene;
                d.cls    = loose_cls;
                d.off    = loose_off;
            end else if (stray_seen) begin
                d.action = ACTION_DENY;
                d.code   = ambig_code;
                d.off    = stray_off;
            end
            expected_decisions = {expected_decisions, d};
            exact_seen = 1'b0; exact_gene = '0; exact_cls = '0; exact_off = '0;
            deny_seen  = 1'b0; deny_code  = '0; deny_off  = '0;
            stray_seen = 1'b0; stray_off  = '0;
            loose_seen = 1'b0; loose_gene = '0; loose_key = '0;
            loose_cls  = '0;   loose_off  = '0;
            clash_seen = 1'b0; clash_off  = '0;
        end
    endfunction

    function automatic logic [S_DATA_W-1:0] pack_hit(hit_t h);
        logic [S_DATA_W-1:0] w;
        w = '0;
        w[S_FIELDS_W-1:0] = {h.rsample, h.off, h.code, h.cls, h.gene, h.sample};
        return w;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // input driver
    hit_t cur_hit;
    int   tx_gap = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                classify_hit(cur_hit);
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_hits.size() > 0) begin
                    cur_hit = pending_hits.pop_front();
                    s_tdata  <= pack_hit(cur_hit);
                    s_tuser  <= cur_hit.valid;
                    s_tlast  <= cur_hit.last;
                    s_tvalid <= 1'b1;
                    tx_gap   = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR: decision %0d %s: got 0x%0h, expected 0x%0h",
                 decisions_seen, what, got, want);
        errors++;
    endtask

    task automatic check_decision(logic [M_DATA_W-1:0] w);
        decision_t want;
        decisions_seen++;
        if (expected_decisions.size() == 0) begin
            report_mismatch("arrived with none pending, word", w[31:0], '0);
        end else begin
            want = expected_decisions.pop_front();
            if (w[1:0] !== want.action)
                report_mismatch("action", 32'(w[1:0]), 32'(want.action));
            if (w[16:2] !== want.gene)
                report_mismatch("gene_index", 32'(w[16:2]), 32'(want.gene));
            if (w[24:17] !== want.cls)
                report_mismatch("class_out", 32'(w[24:17]), 32'(want.cls));
            if (w[32:25] !== want.code)
                report_mismatch("negative_code", 32'(w[32:25]), 32'(want.code));
            if (w[40:33] !== want.off)
                report_mismatch("decision_offset", 32'(w[40:33]), 32'(want.off));
        end
    endtask

    // result monitor with random back-pressure and one long hold-off
    int rx_hold = 0;
    int rx_roll;
    bit long_hold_done = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                check_decision(m_tdata);
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (!long_hold_done && decisions_seen >= 60) begin
                long_hold_done = 1'b1;
                rx_hold = 400;
                m_tready <= 1'b0;
            end else if (steady) begin
                m_tready <= 1'b1;
            end else begin
                rx_roll = $urandom_range(0, 99);
                if (rx_roll < 75) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    rx_hold = (rx_roll < 97) ? $urandom_range(0, 3) : $urandom_range(10, 40);
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_NO_NEGATIVE_CODE:     nonneg_code = val;
            CFG_PROBE_AMBIGUOUS_CODE: ambig_code  = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // wait until every word is sent and every decision is back, then let the pipe empty
    task automatic drain();
        do @(negedge aclk);
        while (pending_hits.size() != 0 || s_tvalid);
        do @(negedge aclk);
        while (expected_decisions.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    function automatic hit_t mk_hit(logic v, logic [15:0] s, logic [14:0] g, logic [7:0] c,
                                    logic [7:0] code, logic [7:0] off, logic [15:0] rs,
                                    logic l);
        hit_t h;
        h = '{valid: v, sample: s, gene: g, cls: c, code: code, off: off,
              rsample: rs, last: l};
        return h;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_read_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return SAMPLE_W'($urandom_range(1, 2));
        if (r < 50)
            return '0;
        if (r < 55)
            return '1;
        return SAMPLE_W'($urandom_range(0, 65535));
    endfunction

    // hit biased towards the interesting cases of a read
    function automatic hit_t rand_hit(logic [SAMPLE_W-1:0] rs);
        hit_t h;
        int   r;
        h.valid   = ($urandom_range(0, 99) >= 5);
        h.rsample = rs;
        r = $urandom_range(0, 99);
        if (r < 45)
            h.sample = rs;
        else if (r < 70)
            h.sample = '0;
        else
            h.sample = rs ^ SAMPLE_W'($urandom_range(1, 65535));
        r = $urandom_range(0, 99);
        if (r < 8)
            h.gene = '0;
        else if (r < 68)
            h.gene = GENE_W'($urandom_range(1, 3));
        else
            h.gene = GENE_W'($urandom_range(0, 32767));
        r = $urandom_range(0, 99);
        if (r < 30)
            h.cls = CLASS_EXACT;
        else if (r < 55)
            h.cls = CLASS_KEEP;
        else if (r < 70)
            h.cls = CLASS_KEEP3;
        else if (r < 85)
            h.cls = CLASS_DENY;
        else
            h.cls = CLASS_W'($urandom_range(0, 255));
        h.code = ($urandom_range(0, 99) < 30) ? nonneg_code : CODE_W'($urandom_range(0, 255));
        h.off  = OFF_W'($urandom_range(0, 255));
        h.last = 1'b0;
        return h;
    endfunction

    // well-formed reads with random content, plus some unframed noise
    task automatic run_random(int budget);
        int            count;
        int            len;
        logic [15:0]   rs;
        hit_t          h;
        count = 0;
        while (count < budget) begin
            if ($urandom_range(0, 99) < 8) begin
                h = mk_hit(1'($urandom_range(0, 1)), SAMPLE_W'($urandom_range(0, 65535)),
                           GENE_W'($urandom_range(0, 32767)),
                           CLASS_W'($urandom_range(0, 255)),
                           CODE_W'($urandom_range(0, 255)), OFF_W'($urandom_range(0, 255)),
                           SAMPLE_W'($urandom_range(0, 65535)),
                           ($urandom_range(0, 3) == 0));
                queue_hit(h);
                count++;
            end else begin
                rs  = pick_read_sample();
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 16) : $urandom_range(1, 5);
                for (int i = 0; i < len; i++) begin
                    h = rand_hit(rs);
                    h.last = (i == len - 1);
                    queue_hit(h);
                    if (h.valid)
                        count++;
                end
            end
        end
        // close any read left open by noise
        h = rand_hit(pick_read_sample());
        h.last = 1'b1;
        queue_hit(h);
    endtask

    // register settings per random phase, extremes included
    logic [7:0] nonneg_set[6] = '{8'd0, 8'd255, 8'd0,   8'd255, 8'd0, 8'd0};
    logic [7:0] ambig_set[6]  = '{8'd1, 8'd0,   8'd255, 8'd255, 8'd0, 8'd7};

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        write_reg(CFG_NO_NEGATIVE_CODE, 8'd0);
        write_reg(CFG_PROBE_AMBIGUOUS_CODE, 8'd1);

        // global keep at the field extremes
        queue_hit(mk_hit(1'b1, 16'h0000, 15'h7fff, CLASS_KEEP, 8'hff, 8'h80, 16'h0000, 1'b1));
        // exact keep, later hits ignored
        queue_hit(mk_hit(1'b1, 16'hffff, 15'd1, CLASS_EXACT, 8'h00, 8'h7f, 16'hffff, 1'b0));
        queue_hit(mk_hit(1'b1, 16'h0000, 15'd0, CLASS_DENY, 8'h05, 8'h01, 16'hffff, 1'b1));
        // unresolved gene with the no-reason code
        queue_hit(mk_hit(1'b1, 16'd5, 15'd0, CLASS_KEEP, 8'h00, 8'h10, 16'd5, 1'b1));
        // deny record then ambiguous, latest wins; read closed by an invalid word
        queue_hit(mk_hit(1'b1, 16'd3, 15'd9, CLASS_DENY, 8'hff, 8'h20, 16'd3, 1'b0));
        queue_hit(mk_hit(1'b1, 16'd0, 15'd0, CLASS_EXACT, 8'h09, 8'h21, 16'd3, 1'b0));
        queue_hit(mk_hit(1'b0, 16'hffff, 15'h7fff, 8'hff, 8'hff, 8'hff, 16'hffff, 1'b1));
        // two other-sample records, first offset kept
        queue_hit(mk_hit(1'b1, 16'd8, 15'd4, CLASS_KEEP, 8'h00, 8'h30, 16'd9, 1'b0));
        queue_hit(mk_hit(1'b1, 16'd7, 15'd4, CLASS_KEEP3, 8'h00, 8'h31, 16'd9, 1'b0));
        queue_hit(mk_hit(1'b0, 16'd0, 15'd0, CLASS_EXACT, 8'h00, 8'h00, 16'd9, 1'b1));
        // conflicting keeps in sample then in gene, latest offset kept
        queue_hit(mk_hit(1'b1, 16'd0, 15'd4, CLASS_KEEP, 8'h00, 8'h40, 16'd9, 1'b0));
        queue_hit(mk_hit(1'b1, 16'd9, 15'd4, CLASS_KEEP3, 8'h00, 8'h41, 16'd9, 1'b0));
        queue_hit(mk_hit(1'b1, 16'd0, 15'd5, CLASS_KEEP, 8'h00, 8'h42, 16'd9, 1'b1));
        // unknown class gives pass
        queue_hit(mk_hit(1'b1, 16'd9, 15'd6, 8'd200, 8'h00, 8'h50, 16'd9, 1'b1));
        // agreeing keeps beat an other-sample record
        queue_hit(mk_hit(1'b1, 16'd9, 15'd6, CLASS_KEEP3, 8'h00, 8'h60, 16'd9, 1'b0));
        queue_hit(mk_hit(1'b1, 16'd9, 15'd6, CLASS_KEEP, 8'h00, 8'h61, 16'd9, 1'b0));
        queue_hit(mk_hit(1'b1, 16'd2, 15'd6, CLASS_KEEP, 8'h00, 8'h62, 16'd9, 1'b1));
        // class 0 global record on a read with sample 0 is not exact
        queue_hit(mk_hit(1'b1, 16'd0, 15'd3, CLASS_EXACT, 8'h00, 8'h70, 16'd0, 1'b1));
        // ambiguous outranks a conflict
        queue_hit(mk_hit(1'b1, 16'd0, 15'd4, CLASS_KEEP, 8'h00, 8'h71, 16'd1, 1'b0));
        queue_hit(mk_hit(1'b1, 16'd0, 15'd5, CLASS_KEEP, 8'h00, 8'h72, 16'd1, 1'b0));
        queue_hit(mk_hit(1'b1, 16'd1, 15'd0, CLASS_KEEP, 8'h4d, 8'h73, 16'd1, 1'b1));
        drain();

        for (int p = 0; p < 6; p++) begin
            if (p == 4) begin
                nonneg_set[p] = 8'($urandom_range(0, 255));
                ambig_set[p]  = 8'($urandom_range(0, 255));
            end
            write_reg(CFG_NO_NEGATIVE_CODE, nonneg_set[p]);
            write_reg(CFG_PROBE_AMBIGUOUS_CODE, ambig_set[p]);
            steady = (p == 2);
            run_random(200);
            drain();
        end

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // hard limit on run time
    initial begin
        #1000000;
        $display("Verification failed");
        $finish;
    end

endmodule
